/* rtl/mer_pkg.sv */
// Shared types, codes and constants of the midpoint ellipse rasterizer.
package mer_pkg;

    // Default widths of the centre coordinates and of the semi-axes.
    localparam int COORD_BITS_DEF = 12;
    localparam int AXIS_BITS_DEF  = 10;

    // Fixed widths of the stream payloads.
    localparam int OUT_W     = 14;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 4 * OUT_W;

    // Centre coordinate after reset.
    localparam int CENTER_RESET = 200;

    // Configuration register indexes.
    localparam logic [1:0] REG_CENTER_X    = 2'd0;
    localparam logic [1:0] REG_CENTER_Y    = 2'd1;
    localparam logic [1:0] REG_SEMI_AXIS_A = 2'd2;
    localparam logic [1:0] REG_SEMI_AXIS_B = 2'd3;

    // Operand pairs of the shared multiplier.
    localparam logic [2:0] MUL_AA      = 3'd0;  // a * a
    localparam logic [2:0] MUL_BB      = 3'd1;  // b * b
    localparam logic [2:0] MUL_ASQ_B   = 3'd2;  // a^2 * b
    localparam logic [2:0] MUL_XX      = 3'd3;  // (2x+1) * (2x+1)
    localparam logic [2:0] MUL_BSQ_P   = 3'd4;  // b^2 * previous product
    localparam logic [2:0] MUL_YY      = 3'd5;  // (y-1) * (y-1)
    localparam logic [2:0] MUL_ASQ_P   = 3'd6;  // a^2 * previous product
    localparam logic [2:0] MUL_ASQ_BSQ = 3'd7;  // a^2 * b^2

    // Operations on the decision register.
    localparam logic [2:0] DEC_HOLD = 3'd0;
    localparam logic [2:0] DEC_INIT = 3'd1;  // start of a new ellipse
    localparam logic [2:0] DEC_STEP = 3'd2;  // one midpoint iteration
    localparam logic [2:0] DEC_LOAD = 3'd3;  // decision = product
    localparam logic [2:0] DEC_ADD4 = 3'd4;  // decision += 4 * product
    localparam logic [2:0] DEC_SUB4 = 3'd5;  // decision -= 4 * product

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic [2:0] mul_sel;
        logic [2:0] dec_op;
        logic       latch_asq;
        logic       latch_bsq;
        logic       eval;
        logic       set_r2;
        logic       load_out;
        logic       zero_out;
    } mer_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;
        logic region2;
        logic cmp;
    } mer_status_t;

endpackage

/* rtl/mer_ctrl.sv */
// Controller state machine of the midpoint ellipse rasterizer.
module mer_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                start_req,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  mer_pkg::mer_status_t status,
    output mer_pkg::mer_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT1 = 4'd1;
    localparam logic [3:0] ST_INIT2 = 4'd2;
    localparam logic [3:0] ST_INIT3 = 4'd3;
    localparam logic [3:0] ST_EVAL  = 4'd4;
    localparam logic [3:0] ST_APPLY = 4'd5;
    localparam logic [3:0] ST_SW_B  = 4'd6;
    localparam logic [3:0] ST_SW_C  = 4'd7;
    localparam logic [3:0] ST_SW_D  = 4'd8;
    localparam logic [3:0] ST_SW_E  = 4'd9;
    localparam logic [3:0] ST_SW_F  = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       zero_reg;
    logic       zero_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       can_load;
    logic       take;

    assign m_tvalid = out_valid_reg;
    assign can_load = !out_valid_reg || m_tready;

    // Next state, commands and the input handshake.
    always_comb
    begin
        state_next      = state_reg;
        zero_next       = zero_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        s_tready        = 1'b0;
        take            = 1'b0;
        cmd             = '0;
        cmd.mul_sel     = mer_pkg::MUL_AA;
        cmd.dec_op      = mer_pkg::DEC_HOLD;
        cmd.zero_out    = zero_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                take     = s_tvalid;
            end
            ST_INIT1:
            begin
                cmd.latch_asq = 1'b1;
                cmd.mul_sel   = mer_pkg::MUL_BB;
                state_next    = ST_INIT2;
            end
            ST_INIT2:
            begin
                cmd.latch_bsq = 1'b1;
                cmd.mul_sel   = mer_pkg::MUL_ASQ_B;
                state_next    = ST_INIT3;
            end
            ST_INIT3:
            begin
                cmd.dec_op = mer_pkg::DEC_INIT;
                state_next = ST_OUT;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                // A failed region-one test reloads the decision first.
                if (!status.region2 && !status.cmp)
                begin
                    cmd.mul_sel = mer_pkg::MUL_XX;
                    state_next  = ST_SW_B;
                end
                else
                begin
                    cmd.dec_op = mer_pkg::DEC_STEP;
                    state_next = ST_OUT;
                end
            end
            ST_SW_B:
            begin
                cmd.mul_sel = mer_pkg::MUL_BSQ_P;
                state_next  = ST_SW_C;
            end
            ST_SW_C:
            begin
                cmd.dec_op  = mer_pkg::DEC_LOAD;
                cmd.mul_sel = mer_pkg::MUL_YY;
                state_next  = ST_SW_D;
            end
            ST_SW_D:
            begin
                cmd.mul_sel = mer_pkg::MUL_ASQ_P;
                state_next  = ST_SW_E;
            end
            ST_SW_E:
            begin
                cmd.dec_op  = mer_pkg::DEC_ADD4;
                cmd.mul_sel = mer_pkg::MUL_ASQ_BSQ;
                state_next  = ST_SW_F;
            end
            ST_SW_F:
            begin
                cmd.dec_op = mer_pkg::DEC_SUB4;
                cmd.set_r2 = 1'b1;
                state_next = ST_EVAL;
            end
            ST_OUT:
            begin
                if (can_load)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    s_tready       = 1'b1;
                    take           = s_tvalid;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // An accepted beat is evaluated at once and branches by its kind.
        if (take)
        begin
            cmd.eval    = 1'b1;
            cmd.mul_sel = mer_pkg::MUL_AA;
            zero_next   = !start_req && !status.active;
            if (start_req)
            begin
                state_next = ST_INIT1;
            end
            else if (status.active)
            begin
                state_next = ST_APPLY;
            end
            else
            begin
                state_next = ST_OUT;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/mer_datapath.sv */
// Datapath of the midpoint ellipse rasterizer: multiplier, decision terms and result register.
module mer_datapath #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [COORD_BITS-1:0]             center_x,
    input  logic [COORD_BITS-1:0]             center_y,
    input  logic [AXIS_BITS-1:0]              semi_axis_a,
    input  logic [AXIS_BITS-1:0]              semi_axis_b,
    input  mer_pkg::mer_cmd_t                 cmd,
    output mer_pkg::mer_status_t              status,
    output logic                              valid_res,
    output logic signed [mer_pkg::OUT_W-1:0]  right_x,
    output logic signed [mer_pkg::OUT_W-1:0]  left_x,
    output logic signed [mer_pkg::OUT_W-1:0]  upper_y,
    output logic signed [mer_pkg::OUT_W-1:0]  lower_y,
    output logic                              last
);

    localparam int OUT_W  = mer_pkg::OUT_W;
    localparam int SQ_W   = 2 * AXIS_BITS;
    localparam int MOP_W  = 2 * AXIS_BITS + 2;
    localparam int PRD_W  = 2 * MOP_W;
    localparam int TERM_W = 3 * AXIS_BITS + 6;
    localparam int DEC_W  = 4 * AXIS_BITS + 8;
    localparam int MAX_W  = (COORD_BITS > AXIS_BITS) ? COORD_BITS : AXIS_BITS;
    localparam int CW     = ((MAX_W > OUT_W) ? MAX_W : OUT_W) + 2;

    // Walk state.
    logic [AXIS_BITS-1:0]     offset_x_reg;
    logic [AXIS_BITS-1:0]     offset_y_reg;
    logic                     region2_reg;
    logic                     active_reg;
    logic [SQ_W-1:0]          a_sq_reg;
    logic [SQ_W-1:0]          b_sq_reg;
    logic [PRD_W-1:0]         mul_reg;
    logic signed [DEC_W-1:0]  dec_reg;
    // Running increments: dx = 4b^2(2x+3), dx2 = 4b^2(2x+2),
    // dy = 4a^2(2-2y), dy2 = 4a^2(3-2y), s4 = 4a^2 + 4b^2.
    logic signed [TERM_W-1:0] dx_reg;
    logic signed [TERM_W-1:0] dx2_reg;
    logic signed [TERM_W-1:0] dy_reg;
    logic signed [TERM_W-1:0] dy2_reg;
    logic signed [TERM_W-1:0] s4_reg;
    logic                     cmp_reg;
    logic signed [TERM_W:0]   inc_reg;

    logic [MOP_W-1:0]         op_a;
    logic [MOP_W-1:0]         op_b;
    logic [AXIS_BITS-1:0]     y_m1;
    logic signed [TERM_W-1:0] a2;
    logic signed [TERM_W-1:0] b2;
    logic signed [TERM_W-1:0] pt;
    logic signed [TERM_W:0]   sum_xy;
    logic signed [TERM_W:0]   inc_next;
    logic signed [DEC_W-1:0]  prod_ext;
    logic signed [DEC_W-1:0]  prod4;
    logic signed [DEC_W-1:0]  dec_next;
    logic                     dec_pos;
    logic                     x_adv;
    logic                     y_dec;
    logic                     x_sat;
    logic signed [CW-1:0]     right_full;
    logic signed [CW-1:0]     left_full;
    logic signed [CW-1:0]     upper_full;
    logic signed [CW-1:0]     lower_full;

    assign status.active  = active_reg;
    assign status.region2 = region2_reg;
    assign status.cmp     = cmp_reg;

    assign y_m1    = offset_y_reg - 1'b1;
    assign a2      = $signed(TERM_W'(a_sq_reg));
    assign b2      = $signed(TERM_W'(b_sq_reg));
    assign pt      = $signed(mul_reg[TERM_W-1:0]);
    assign dec_pos = !dec_reg[DEC_W-1] && (dec_reg != '0);
    assign x_sat   = (offset_x_reg == {AXIS_BITS{1'b1}});
    assign x_adv   = region2_reg ? !dec_pos : 1'b1;
    assign y_dec   = region2_reg ? 1'b1 : dec_pos;

    // Operand selection of the shared multiplier.
    always_comb
    begin
        unique case (cmd.mul_sel)
            mer_pkg::MUL_AA:
            begin
                op_a = MOP_W'(semi_axis_a);
                op_b = MOP_W'(semi_axis_a);
            end
            mer_pkg::MUL_BB:
            begin
                op_a = MOP_W'(semi_axis_b);
                op_b = MOP_W'(semi_axis_b);
            end
            mer_pkg::MUL_ASQ_B:
            begin
                op_a = MOP_W'(a_sq_reg);
                op_b = MOP_W'(semi_axis_b);
            end
            mer_pkg::MUL_XX:
            begin
                op_a = MOP_W'({offset_x_reg, 1'b1});
                op_b = MOP_W'({offset_x_reg, 1'b1});
            end
            mer_pkg::MUL_BSQ_P:
            begin
                op_a = MOP_W'(b_sq_reg);
                op_b = mul_reg[MOP_W-1:0];
            end
            mer_pkg::MUL_YY:
            begin
                op_a = MOP_W'(y_m1);
                op_b = MOP_W'(y_m1);
            end
            mer_pkg::MUL_ASQ_P:
            begin
                op_a = MOP_W'(a_sq_reg);
                op_b = mul_reg[MOP_W-1:0];
            end
            mer_pkg::MUL_ASQ_BSQ:
            begin
                op_a = MOP_W'(a_sq_reg);
                op_b = MOP_W'(b_sq_reg);
            end
        endcase
    end

    // Region-one test and the increment chosen for the next step.
    always_comb
    begin
        sum_xy = (TERM_W + 1)'(dx_reg) + (TERM_W + 1)'(dy_reg);
        if (region2_reg)
        begin
            if (dec_pos)
            begin
                inc_next = (TERM_W + 1)'(dy2_reg);
            end
            else
            begin
                inc_next = (TERM_W + 1)'(dx2_reg) + (TERM_W + 1)'(dy2_reg);
            end
        end
        else
        begin
            if (dec_pos)
            begin
                inc_next = sum_xy;
            end
            else
            begin
                inc_next = (TERM_W + 1)'(dx_reg);
            end
        end
    end

    // Next decision value.
    always_comb
    begin
        prod_ext = $signed(DEC_W'(mul_reg));
        prod4    = prod_ext <<< 2;
        unique case (cmd.dec_op)
            mer_pkg::DEC_INIT: dec_next = (DEC_W'(b2) <<< 2) + DEC_W'(a2) - prod4;
            mer_pkg::DEC_STEP: dec_next = dec_reg + DEC_W'(inc_reg);
            mer_pkg::DEC_LOAD: dec_next = prod_ext;
            mer_pkg::DEC_ADD4: dec_next = dec_reg + prod4;
            mer_pkg::DEC_SUB4: dec_next = dec_reg - prod4;
            default:           dec_next = dec_reg;
        endcase
    end

    // Point coordinates from the live centre.
    assign right_full = $signed(CW'(center_x)) + $signed(CW'(offset_x_reg));
    assign left_full  = $signed(CW'(center_x)) - $signed(CW'(offset_x_reg));
    assign upper_full = $signed(CW'(center_y)) + $signed(CW'(offset_y_reg));
    assign lower_full = $signed(CW'(center_y)) - $signed(CW'(offset_y_reg));

    // Control flags of the walk.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            region2_reg <= 1'b0;
        end
        else if (cmd.dec_op == mer_pkg::DEC_INIT)
        begin
            active_reg  <= (semi_axis_b != '0);
            region2_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_r2)
            begin
                region2_reg <= 1'b1;
            end
            if (cmd.dec_op == mer_pkg::DEC_STEP && y_dec)
            begin
                active_reg <= (y_m1 != '0);
            end
        end
    end

    // Multiplier, squares, decision and running increments.
    always_ff @(posedge clk)
    begin
        mul_reg <= op_a * op_b;
        dec_reg <= dec_next;
        if (cmd.latch_asq)
        begin
            a_sq_reg <= mul_reg[SQ_W-1:0];
        end
        if (cmd.latch_bsq)
        begin
            b_sq_reg <= mul_reg[SQ_W-1:0];
        end
        if (cmd.eval)
        begin
            cmp_reg <= (sum_xy < (TERM_W + 1)'(s4_reg));
            inc_reg <= inc_next;
        end

        if (cmd.dec_op == mer_pkg::DEC_INIT)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= semi_axis_b;
            dx_reg       <= (b2 <<< 3) + (b2 <<< 2);
            dx2_reg      <= b2 <<< 3;
            dy_reg       <= (a2 <<< 3) - (pt <<< 3);
            dy2_reg      <= (a2 <<< 3) + (a2 <<< 2) - (pt <<< 3);
            s4_reg       <= (a2 <<< 2) + (b2 <<< 2);
        end
        else if (cmd.dec_op == mer_pkg::DEC_STEP)
        begin
            if (x_adv && !x_sat)
            begin
                offset_x_reg <= offset_x_reg + 1'b1;
                dx_reg       <= dx_reg + (b2 <<< 3);
                dx2_reg      <= dx2_reg + (b2 <<< 3);
            end
            if (y_dec)
            begin
                offset_y_reg <= y_m1;
                dy_reg       <= dy_reg + (a2 <<< 3);
                dy2_reg      <= dy2_reg + (a2 <<< 3);
            end
        end
    end

    // Result register, loaded when the output side has room.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (cmd.zero_out)
            begin
                valid_res <= 1'b0;
                right_x   <= '0;
                left_x    <= '0;
                upper_y   <= '0;
                lower_y   <= '0;
                last      <= 1'b0;
            end
            else
            begin
                valid_res <= 1'b1;
                right_x   <= $signed(right_full[OUT_W-1:0]);
                left_x    <= $signed(left_full[OUT_W-1:0]);
                upper_y   <= $signed(upper_full[OUT_W-1:0]);
                lower_y   <= $signed(lower_full[OUT_W-1:0]);
                last      <= (offset_y_reg == '0);
            end
        end
    end

endmodule

/* rtl/midpoint_ellipse_rasterizer_top.sv */
// Top level of the midpoint ellipse rasterizer: configuration registers and stream ports.
// Each input beat either starts a new ellipse (start_req set) at offset (0, b) or advances the
// current one by one midpoint iteration, and each gives exactly one output beat with the four
// symmetric points; tlast marks the final point set, and a step beat with no ellipse running
// gives a beat with tuser clear and zero data. The single shared multiplier, one product a cycle,
// builds the squared semi-axes at a start and the reloaded decision value at the step on which
// the walk passes from region one to region two, so a start and that step take longer than
// other steps. The next input beat is taken while a finished result still waits on the output
// side. The centre registers are read live for every beat; the semi-axes take effect at the
// next start. Write the configuration only while the block is idle.
module midpoint_ellipse_rasterizer_top #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [mer_pkg::S_TDATA_W-1:0]          s_tdata,   // [0] start_req
    // Output stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [mer_pkg::M_TDATA_W-1:0]          m_tdata,   // right_x, left_x, upper_y, lower_y
    output logic [0:0]                             m_tuser,   // [0] valid_res
    output logic                                   m_tlast,
    // Configuration write port.
    input  logic                                   cfg_we,
    input  logic [1:0]                             cfg_addr,
    input  logic [((COORD_BITS > AXIS_BITS) ? COORD_BITS : AXIS_BITS)-1:0] cfg_wdata
);

    logic [COORD_BITS-1:0]                center_x_reg;
    logic [COORD_BITS-1:0]                center_y_reg;
    logic [AXIS_BITS-1:0]                 semi_axis_a_reg;
    logic [AXIS_BITS-1:0]                 semi_axis_b_reg;
    mer_pkg::mer_cmd_t                    cmd;
    mer_pkg::mer_status_t                 status;
    logic signed [mer_pkg::OUT_W-1:0]     right_x;
    logic signed [mer_pkg::OUT_W-1:0]     left_x;
    logic signed [mer_pkg::OUT_W-1:0]     upper_y;
    logic signed [mer_pkg::OUT_W-1:0]     lower_y;
    logic                                 valid_res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= COORD_BITS'(mer_pkg::CENTER_RESET);
            center_y_reg    <= COORD_BITS'(mer_pkg::CENTER_RESET);
            semi_axis_a_reg <= '0;
            semi_axis_b_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                mer_pkg::REG_CENTER_X:    center_x_reg    <= cfg_wdata[COORD_BITS-1:0];
                mer_pkg::REG_CENTER_Y:    center_y_reg    <= cfg_wdata[COORD_BITS-1:0];
                mer_pkg::REG_SEMI_AXIS_A: semi_axis_a_reg <= cfg_wdata[AXIS_BITS-1:0];
                mer_pkg::REG_SEMI_AXIS_B: semi_axis_b_reg <= cfg_wdata[AXIS_BITS-1:0];
            endcase
        end
    end

    // Sequencer.
    mer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .start_req (s_tdata[0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and result register.
    mer_datapath #(
        .COORD_BITS (COORD_BITS),
        .AXIS_BITS  (AXIS_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .semi_axis_a (semi_axis_a_reg),
        .semi_axis_b (semi_axis_b_reg),
        .cmd         (cmd),
        .status      (status),
        .valid_res   (valid_res),
        .right_x     (right_x),
        .left_x      (left_x),
        .upper_y     (upper_y),
        .lower_y     (lower_y),
        .last        (m_tlast)
    );

    // Output beat packing, first field in the lowest bits.
    assign m_tdata = {lower_y, upper_y, left_x, right_x};
    assign m_tuser = valid_res;

endmodule
